// ===== design/acp_pkg.sv =====
// Shared types, keyword tables and constants for the ASCII line command parser.
`timescale 1ns / 1ps

package acp_pkg;

  // Longest line kept before it is thrown away; legal range 9 to 256.
  localparam int LINE_LIMIT = 64;
  localparam int CNT_W = $clog2(LINE_LIMIT);

  localparam int KW_COUNT = 7;
  localparam int VALUE_START = 6;
  localparam int VALUE_W = 32;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_INVALID  = 3'd0;
  localparam cmd_t CMD_GETMV    = 3'd1;
  localparam cmd_t CMD_GETMA    = 3'd2;
  localparam cmd_t CMD_SETMV    = 3'd3;
  localparam cmd_t CMD_SETMA    = 3'd4;
  localparam cmd_t CMD_GETTEMP  = 3'd5;
  localparam cmd_t CMD_GETCTRL  = 3'd6;
  localparam cmd_t CMD_DROPCTRL = 3'd7;

  // Number scanner phases.
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Keyword text, first character in the top byte, padded with zeros.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"GetmV", 24'h0},
    {"GetmA", 24'h0},
    {"SetmV", 24'h0},
    {"SetmA", 24'h0},
    {"GetTemp", 8'h0},
    {"GetCtrl", 8'h0},
    "DropCtrl"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd5, 4'd5, 4'd5, 4'd7, 4'd7, 4'd8
  };

  localparam cmd_t KW_CODE [KW_COUNT] = '{
    CMD_GETMV, CMD_GETMA, CMD_SETMV, CMD_SETMA, CMD_GETTEMP, CMD_GETCTRL, CMD_DROPCTRL
  };

  typedef struct packed {
    cmd_t               command_code;
    logic [VALUE_W-1:0] set_value;
    logic               value_missing;
  } acp_result_t;

endpackage

// ===== design/acp_in_reg.sv =====
// Input register that holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module acp_in_reg
  import acp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  // The register may refill in the same cycle that its byte is taken.
  assign in_ready = !byte_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

// ===== design/acp_parse_core.sv =====
// Per-byte line state: keyword match flags, number scanner and line length.
`timescale 1ns / 1ps

module acp_parse_core
  import acp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic [7:0]  byte_q,
  input  logic        out_free,
  output logic        take,
  output logic        res_valid,
  output acp_result_t res
);

  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [KW_COUNT-1:0] keyword_still_matching, keyword_still_matching_next;
  logic [1:0]         number_phase, number_phase_next;
  logic               number_negative, number_negative_next;
  logic               digits_seen, digits_seen_next;
  logic [VALUE_W-1:0] number_accumulator, number_accumulator_next;

  logic is_nl, is_blank, is_digit, is_sign;
  logic in_digit_phase;
  cmd_t line_code;
  logic [VALUE_W-1:0] acc_times_ten;

  assign is_nl    = (byte_q == CHAR_NL);
  assign is_blank = (byte_q == CHAR_SPACE) || (byte_q >= CHAR_TAB && byte_q <= CHAR_CR);
  assign is_digit = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
  assign is_sign  = (byte_q == CHAR_PLUS) || (byte_q == CHAR_MINUS);
  assign acc_times_ten = (number_accumulator << 3) + (number_accumulator << 1);

  assign take = byte_valid && out_free;

  // Later keywords in the table win when more than one would match.
  always_comb begin
    line_code = CMD_INVALID;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (keyword_still_matching[k] && (byte_count >= CNT_W'(KW_LEN[k]))) begin
        line_code = KW_CODE[k];
      end
    end
  end

  always_comb begin
    byte_count_next             = byte_count;
    keyword_still_matching_next = keyword_still_matching;
    number_phase_next           = number_phase;
    number_negative_next        = number_negative;
    digits_seen_next            = digits_seen;
    number_accumulator_next     = number_accumulator;
    in_digit_phase              = 1'b0;
    res_valid                   = 1'b0;
    res.command_code            = line_code;
    res.set_value               = '0;
    res.value_missing           = 1'b0;

    if (take && is_nl) begin
      res_valid = 1'b1;
      if (line_code == CMD_SETMV || line_code == CMD_SETMA) begin
        if (digits_seen) begin
          res.set_value = number_negative ? (VALUE_W'(0) - number_accumulator)
                                          : number_accumulator;
        end else begin
          res.value_missing = 1'b1;
        end
      end
    end

    if (take && !is_nl) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if ((byte_count < CNT_W'(KW_LEN[k])) &&
            (byte_q != KW_TEXT[k][{~byte_count[2:0], 3'b000} +: 8])) begin
          keyword_still_matching_next[k] = 1'b0;
        end
      end

      if (byte_count >= CNT_W'(VALUE_START)) begin
        unique case (number_phase)
          PH_SKIP: begin
            if (is_sign) begin
              number_negative_next = (byte_q == CHAR_MINUS);
              number_phase_next    = PH_SIGN;
            end else if (!is_blank) begin
              in_digit_phase = 1'b1;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            in_digit_phase = 1'b1;
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase

        if (in_digit_phase) begin
          if (is_digit) begin
            number_accumulator_next = acc_times_ten + VALUE_W'(byte_q[3:0]);
            digits_seen_next        = 1'b1;
            number_phase_next       = PH_DIGITS;
          end else begin
            number_phase_next = PH_DONE;
          end
        end
      end

      byte_count_next = byte_count + CNT_W'(1);
    end

    // A newline or an overlong line starts the next line from scratch.
    if (take && (is_nl || (byte_count == CNT_W'(LINE_LIMIT - 1)))) begin
      byte_count_next             = '0;
      keyword_still_matching_next = '1;
      number_phase_next           = PH_SKIP;
      number_negative_next        = 1'b0;
      digits_seen_next            = 1'b0;
      number_accumulator_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count             <= '0;
      keyword_still_matching <= '1;
      number_phase           <= PH_SKIP;
      number_negative        <= 1'b0;
      digits_seen            <= 1'b0;
      number_accumulator     <= '0;
    end else begin
      byte_count             <= byte_count_next;
      keyword_still_matching <= keyword_still_matching_next;
      number_phase           <= number_phase_next;
      number_negative        <= number_negative_next;
      digits_seen            <= digits_seen_next;
      number_accumulator     <= number_accumulator_next;
    end
  end

endmodule

// ===== design/acp_out_reg.sv =====
// Result register that holds one decoded command until it is taken.
`timescale 1ns / 1ps

module acp_out_reg
  import acp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  acp_result_t        res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output cmd_t               command_code,
  output logic [VALUE_W-1:0] set_value,
  output logic               value_missing
);

  acp_result_t held;

  assign out_free      = !out_valid || out_ready;
  assign command_code  = held.command_code;
  assign set_value     = held.set_value;
  assign value_missing = held.value_missing;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ===== design/ascii_line_command_parser.sv =====
// Top level of the ASCII line command parser.
`timescale 1ns / 1ps

// The parser takes one received byte per request on the input channel and
// gathers a line up to a newline (0x0A). At the newline it delivers one
// request on the output channel: a command code (0 invalid, 1 GetmV, 2 GetmA,
// 3 SetmV, 4 SetmA, 5 GetTemp, 6 GetCtrl, 7 DropCtrl) chosen by matching the
// line prefix against the keywords, and for the two set commands a decimal
// value read from line byte 6 on (leading white space skipped, optional sign,
// digits, wrapping modulo 2^32). A set command without digits reports value
// 0 with value_missing high; every other command reports value 0 and the flag
// low. An empty or unknown line still gives a request with code 0. A line
// that reaches 64 bytes without a newline is dropped with no output. No line
// buffer is kept: keyword flags and the number accumulator are updated as
// each byte goes by. The block takes one byte every clock cycle as long as
// results are taken; a byte passes an input register, combinational parsing
// logic and a result register, which is loaded as the newline leaves the
// input register. The only stall comes from the result register: while
// a result waits for out_ready, at most one more byte is held at the input.

module ascii_line_command_parser
  import acp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         command_code,
  output logic [VALUE_W-1:0] set_value,
  output logic               value_missing
);

  logic        take;
  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        out_free;
  logic        res_valid;
  acp_result_t res;

  acp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  acp_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_q     (byte_q),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  acp_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (res_valid),
    .res           (res),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command_code  (command_code),
    .set_value     (set_value),
    .value_missing (value_missing)
  );

endmodule

// ===== design/acp_checker.sv =====
// Port-level checks for the ASCII line command parser, bound to the top level.
`timescale 1ns / 1ps

module acp_checker
  import acp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         rx_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         command_code,
  input logic [VALUE_W-1:0] set_value,
  input logic               value_missing
);

  // A waiting result must hold still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command_code) &&
      $stable(set_value) && $stable(value_missing))
    else $error("result changed while stalled");

  // With no result pending the input side never stalls.
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Only set commands carry a value or a missing-value flag.
  a_value_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_code != CMD_SETMV && command_code != CMD_SETMA |->
      set_value == '0 && !value_missing)
    else $error("value reported for a command that takes none");

  // A missing value always reads as zero.
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_missing |-> set_value == '0)
    else $error("missing value flag with nonzero value");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind ascii_line_command_parser acp_checker u_acp_checker (.*);

// ===== verif/command_line_checker.sv =====
// Checker for the ASCII line command parser: byte-level predictor and result comparison.
`timescale 1ns / 1ps

module command_line_checker
  import acp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  command_code,
  input  logic [31:0] set_value,
  input  logic        value_missing,
  output int          mismatch_count,
  output int          outstanding
);

  // Running state of the line being gathered.
  int unsigned         line_len;
  logic [KW_COUNT-1:0] kw_alive;
  logic [1:0]          scan_phase;
  logic                scan_neg;
  logic                got_digit;
  logic [31:0]         scan_acc;

  acp_result_t expected_commands[$];

  // Keyword text, left-justified, first character in the top byte.
  function automatic logic [63:0] keyword_text(input int k);
    case (k)
      0:       return {"GetmV", 24'h0};
      1:       return {"GetmA", 24'h0};
      2:       return {"SetmV", 24'h0};
      3:       return {"SetmA", 24'h0};
      4:       return {"GetTemp", 8'h0};
      5:       return {"GetCtrl", 8'h0};
      default: return "DropCtrl";
    endcase
  endfunction

  function automatic int keyword_length(input int k);
    case (k)
      0, 1, 2, 3: return 5;
      4, 5:       return 7;
      default:    return 8;
    endcase
  endfunction

  function automatic cmd_t keyword_code(input int k);
    case (k)
      0:       return CMD_GETMV;
      1:       return CMD_GETMA;
      2:       return CMD_SETMV;
      3:       return CMD_SETMA;
      4:       return CMD_GETTEMP;
      5:       return CMD_GETCTRL;
      default: return CMD_DROPCTRL;
    endcase
  endfunction

  function automatic logic [7:0] keyword_char(input int k, input int pos);
    logic [63:0] text;
    text = keyword_text(k);
    return text[63 - 8 * pos -: 8];
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  task automatic clear_line();
    line_len   = 0;
    kw_alive   = '1;
    scan_phase = PH_SKIP;
    scan_neg   = 1'b0;
    got_digit  = 1'b0;
    scan_acc   = '0;
  endtask

  // Number scanner: blanks, then an optional sign, then digits up to the first other byte.
  task automatic scan_value_byte(input logic [7:0] b);
    logic is_digit;
    logic take;
    is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
    take = 1'b1;
    if (scan_phase == PH_SKIP) begin
      if (is_blank(b)) begin
        take = 1'b0;
      end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
        scan_neg   = (b == CHAR_MINUS);
        scan_phase = PH_SIGN;
        take       = 1'b0;
      end else begin
        scan_phase = PH_SIGN;
      end
    end
    if (take && (scan_phase == PH_SIGN || scan_phase == PH_DIGITS)) begin
      if (is_digit) begin
        scan_acc   = scan_acc * 32'd10 + 32'(b - CHAR_ZERO);
        got_digit  = 1'b1;
        scan_phase = PH_DIGITS;
      end else begin
        scan_phase = PH_DONE;
      end
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    acp_result_t cmd;
    if (b == CHAR_NL) begin
      cmd.command_code  = CMD_INVALID;
      cmd.set_value     = '0;
      cmd.value_missing = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        if (kw_alive[k] && line_len >= keyword_length(k)) begin
          cmd.command_code = keyword_code(k);
        end
      end
      if (cmd.command_code == CMD_SETMV || cmd.command_code == CMD_SETMA) begin
        if (got_digit) begin
          cmd.set_value = scan_neg ? (32'd0 - scan_acc) : scan_acc;
        end else begin
          cmd.value_missing = 1'b1;
        end
      end
      expected_commands.push_back(cmd);
      clear_line();
    end else begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (line_len < keyword_length(k) && b != keyword_char(k, line_len)) begin
          kw_alive[k] = 1'b0;
        end
      end
      if (line_len >= VALUE_START) begin
        scan_value_byte(b);
      end
      line_len++;
      if (line_len >= LINE_LIMIT) begin
        clear_line();
      end
    end
  endtask

  task automatic check_command();
    acp_result_t want;
    if (expected_commands.size() == 0) begin
      $error("unexpected result: command_code %0d set_value 0x%08h value_missing %0b",
             command_code, set_value, value_missing);
      mismatch_count++;
    end else begin
      want = expected_commands.pop_front();
      if (command_code !== want.command_code) begin
        $error("command_code: expected %0d, actual %0d", want.command_code, command_code);
        mismatch_count++;
      end
      if (set_value !== want.set_value) begin
        $error("set_value: expected 0x%08h, actual 0x%08h", want.set_value, set_value);
        mismatch_count++;
      end
      if (value_missing !== want.value_missing) begin
        $error("value_missing: expected %0b, actual %0b", want.value_missing, value_missing);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      expected_commands.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_command();
      end
      if (in_valid && in_ready) begin
        decode_rx_byte(rx_byte);
      end
    end
    outstanding = expected_commands.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the parser testbench: clock, reset, byte stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

// The testbench feeds received bytes to the parser one request at a time and
// takes its command results with a randomly stalling ready. All prediction and
// comparison happens in command_line_checker, which sits beside the parser and
// watches both channels; this module only produces traffic and decides the
// verdict from the checker's mismatch count.
//
// Traffic starts with hand-written lines that hit every keyword, lines that
// are too short for a keyword, keywords followed by extra text, the set
// commands with plain, signed, blank-led and wrapping values, set commands
// without digits, the ignored byte in front of the value, lines that hit the
// length limit, and empty or unknown lines. After that come random lines,
// most of them shaped like real commands with random numbers, the rest noise,
// broken keywords and overlong lines, until about 1500 bytes have gone in.
// Both sides idle in random bursts; toward the end both run without gaps.

module testbench
  import acp_pkg::*;
();

  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_X  = 8'h78;

  // Byte totals that steer the run: where the gap-free tail begins and where stimulus stops.
  localparam int CALM_AFTER  = 1300;
  localparam int BYTE_TARGET = 1500;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  command_code;
  logic [31:0] set_value;
  logic        value_missing;

  int mismatch_count;
  int outstanding;

  // Once set, neither side inserts idle cycles any more.
  bit calm;
  int byte_total;
  // Chance in percent that a byte is preceded by an idle burst; chosen per line.
  int gap_pct;

  string kw_words[KW_COUNT] = '{"GetmV", "GetmA", "SetmV", "SetmA",
                                "GetTemp", "GetCtrl", "DropCtrl"};

  ascii_line_command_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command_code (command_code),
    .set_value    (set_value),
    .value_missing(value_missing)
  );

  command_line_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command_code  (command_code),
    .set_value     (set_value),
    .value_missing (value_missing),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the parser hangs or a result never shows up.
  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // One byte request. Inputs move only on the falling edge; acceptance is
  // seen at the rising edge where valid and ready are both high.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    byte_total++;
    if (byte_total >= CALM_AFTER) begin
      calm = 1'b1;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Text padded with filler up to a given line length, with or without a newline.
  task automatic send_padded(input string s, input int total, input bit with_nl);
    send_text(s);
    for (int i = s.len(); i < total; i++) begin
      send_byte(CHAR_X);
    end
    if (with_nl) begin
      send_byte(CHAR_NL);
    end
  endtask

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_NL);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0:       return CHAR_TAB;
      1:       return CHAR_VT;
      2:       return CHAR_FF;
      3:       return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  // One random line. Most are command shaped so that the keyword match and
  // the number scanner get past their first states; the rest is noise,
  // overlong lines and cut-off keywords.
  task automatic send_random_line();
    logic [7:0] line_q[$];
    string      word;
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    word = kw_words[$urandom_range(0, KW_COUNT - 1)];
    case ($urandom_range(0, 3))
      0, 1:    gap_pct = 0;
      2:       gap_pct = 5;
      default: gap_pct = 30;
    endcase
    if (pick < 70) begin
      for (int i = 0; i < word.len(); i++) begin
        line_q.push_back(word[i]);
      end
      // Now and then one keyword character goes wrong.
      if ($urandom_range(0, 9) == 0) begin
        line_q[$urandom_range(0, line_q.size() - 1)] = any_but_newline();
      end
      // The byte just before the value field is skipped by the parser.
      if (word.len() == 5) begin
        line_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : any_but_newline());
      end
      repeat ($urandom_range(0, 3)) line_q.push_back(blank_byte());
      case ($urandom_range(0, 3))
        0:       line_q.push_back(CHAR_PLUS);
        1:       line_q.push_back(CHAR_MINUS);
        default: ;
      endcase
      // Mostly short numbers; a few long enough to wrap around 32 bits.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 10);
      repeat (n) line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      repeat ($urandom_range(0, 3)) line_q.push_back(any_but_newline());
      line_q.push_back(CHAR_NL);
    end else if (pick < 85) begin
      // Raw noise; a stray newline in here simply splits the line.
      repeat ($urandom_range(0, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CHAR_NL);
    end else if (pick < 93) begin
      // Lines around the length limit, with or without a keyword in front.
      n = $urandom_range(LINE_LIMIT - 3, LINE_LIMIT + 6);
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < word.len(); i++) begin
          line_q.push_back(word[i]);
        end
      end
      while (line_q.size() < n) begin
        line_q.push_back($urandom_range(0, 1) ? 8'(CHAR_ZERO + $urandom_range(0, 9))
                                              : any_but_newline());
      end
      if ($urandom_range(0, 3) != 0) begin
        line_q.push_back(CHAR_NL);
      end
    end else begin
      // A keyword cut short, down to the empty line.
      n = $urandom_range(0, word.len());
      for (int i = 0; i < n; i++) begin
        line_q.push_back(word[i]);
      end
      line_q.push_back(CHAR_NL);
    end
    foreach (line_q[i]) begin
      send_byte(line_q[i]);
    end
  endtask

  // Result side: windows of varying stall rates, some with no stalls at all.
  initial begin
    int window;
    int rate;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      window = $urandom_range(20, 200);
      case ($urandom_range(0, 2))
        0:       rate = 0;
        1:       rate = 4;
        default: rate = 20;
      endcase
      repeat (window) begin
        if (!calm && rate != 0 && $urandom_range(0, 99) < rate) begin
          out_ready = 1'b0;
          repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = '0;
    calm       = 1'b0;
    byte_total = 0;
    gap_pct    = 5;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Every keyword on its own.
    foreach (kw_words[i]) begin
      send_text(kw_words[i]);
      send_byte(CHAR_NL);
    end
    // Keywords with trailing text still match; a cut-off or lowercase one does not.
    send_text("GetmVextra\n");
    send_text("DropCtr\n");
    send_text("setmv 1\n");
    send_text("Get\n");
    send_byte(CHAR_NL);
    // Set commands: plain, negative, blank-led with plus sign, wrapping.
    send_text("SetmV 1234\n");
    send_text("SetmA -56\n");
    send_text("SetmA\t +4294967295x\n");
    send_text("SetmV 99999999999\n");
    send_text("SetmV -0\n");
    // The byte in front of the value is skipped whatever it holds.
    send_text("SetmV5 12\n");
    send_text("SetmV-7\n");
    // Set commands without digits: too short, sign alone, other text.
    send_text("SetmV\n");
    send_text("SetmA  -\n");
    send_text("SetmV abc\n");
    // One byte short of the limit still gives a result.
    send_padded("SetmA 42 ", LINE_LIMIT - 1, 1'b1);
    // At the limit the line is dropped and the next bytes start afresh.
    send_padded("SetmA 42 ", LINE_LIMIT, 1'b0);
    send_text("GetmA\n");
    send_padded("", LINE_LIMIT, 1'b1);

    while (byte_total < BYTE_TARGET) begin
      send_random_line();
    end
    // A line that ends right now, so the stream closes on a result.
    send_text("SetmV 7\n");

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    // Let anything stray in the pipeline come out before the verdict.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
